/* rtl/core/fast_rsqrt_vec3_normalize_unit_assert.svh */
// Assertion macros for the vector normalize unit checkers.
// Depends on nothing; included by checker files.
`ifndef FAST_RSQRT_VEC3_NORMALIZE_UNIT_ASSERT_SVH
`define FAST_RSQRT_VEC3_NORMALIZE_UNIT_ASSERT_SVH
// Check a property while out of reset
`define FVN_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fvn assertion failed");
// Check a property at every edge, reset included
`define FVN_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("fvn assertion failed");
`endif

/* rtl/core/fvn_pkg.sv */
// Package for the vector normalize unit: payload types, constants and
// binary32 multiply/add functions with round-to-nearest-even. No dependencies.
package fvn_pkg;

    typedef struct packed {
        logic [31:0] x_bits;
        logic [31:0] y_bits;
        logic [31:0] z_bits;
    } t_vec_in;

    typedef struct packed {
        logic [31:0] nx_bits;
        logic [31:0] ny_bits;
        logic [31:0] nz_bits;
    } t_vec_out;

    localparam int FVN_STAGES = 9;
    localparam logic [31:0] FVN_SEED_MAGIC = 32'h5f3759df;
    localparam logic [31:0] FVN_ONE_HALF   = 32'h3f000000;
    localparam logic [31:0] FVN_THREE_HALF = 32'h3fc00000;
    localparam logic [31:0] FVN_QNAN       = 32'h7fc00000;
    localparam logic [30:0] FVN_INF_MAG    = 31'h7f800000;

    // Round value mag * 2^e2 (mag nonzero) to binary32
    function automatic logic [31:0] fp_round(input logic sgn, input logic [49:0] mag,
                                             input logic signed [12:0] e2);
        logic [5:0]         lz;
        logic               found;
        logic [49:0]        norm;
        logic signed [12:0] be;
        logic [12:0]        sh;
        logic               stk;
        logic [23:0]        kept;
        logic               rnd;
        logic [32:0]        w;
        lz    = '0;
        found = 1'b0;
        for (int i = 49; i >= 0; i--) begin
            if (!found) begin
                if (mag[i]) found = 1'b1;
                else lz = lz + 6'd1;
            end
        end
        norm = mag << lz;
        be   = e2 + 13'sd176 - $signed({7'd0, lz});
        stk  = 1'b0;
        // denormalize below the smallest normal exponent
        if (be < 13'sd1) begin
            sh = 13'(13'sd1 - be);
            if (sh > 13'd49) begin
                stk  = |norm;
                norm = '0;
            end else begin
                stk  = |(norm & ((50'd1 << sh) - 50'd1));
                norm = norm >> sh;
            end
            be = 13'sd1;
        end
        kept = norm[49:26];
        rnd  = norm[25] & ((|norm[24:0]) | stk | kept[0]);
        if (be >= 13'sd255) begin
            return {sgn, FVN_INF_MAG};
        end
        w = (33'(unsigned'(be - 13'sd1)) << 23) + {9'd0, kept} + {32'd0, rnd};
        if (w >= {2'b0, FVN_INF_MAG}) return {sgn, FVN_INF_MAG};
        return {sgn, w[30:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        sgn;
        logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic [7:0]  ea, eb;
        logic [23:0] ma, mb;
        logic [47:0] p;
        logic signed [12:0] e2;
        sgn    = a[31] ^ b[31];
        a_nan  = (a[30:23] == 8'hff) && (a[22:0] != '0);
        b_nan  = (b[30:23] == 8'hff) && (b[22:0] != '0);
        a_inf  = (a[30:0] == FVN_INF_MAG);
        b_inf  = (b[30:0] == FVN_INF_MAG);
        a_zero = (a[30:0] == '0);
        b_zero = (b[30:0] == '0);
        ea     = (a[30:23] == '0) ? 8'd1 : a[30:23];
        eb     = (b[30:23] == '0) ? 8'd1 : b[30:23];
        ma     = {(a[30:23] != '0), a[22:0]};
        mb     = {(b[30:23] != '0), b[22:0]};
        p      = ma * mb;
        e2     = $signed({5'd0, ea}) + $signed({5'd0, eb}) - 13'sd300;
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) return FVN_QNAN;
        if (a_inf || b_inf) return {sgn, FVN_INF_MAG};
        if (a_zero || b_zero) return {sgn, 31'd0};
        return fp_round(sgn, {2'b0, p}, e2);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] big, sml;
        logic        a_nan, b_nan, a_inf, b_inf;
        logic [7:0]  eg, es, d;
        logic [49:0] mg, ms, sum;
        logic        stk;
        a_nan = (a[30:23] == 8'hff) && (a[22:0] != '0);
        b_nan = (b[30:23] == 8'hff) && (b[22:0] != '0);
        a_inf = (a[30:0] == FVN_INF_MAG);
        b_inf = (b[30:0] == FVN_INF_MAG);
        if (a[30:0] < b[30:0]) begin
            big = b;
            sml = a;
        end else begin
            big = a;
            sml = b;
        end
        eg  = (big[30:23] == '0) ? 8'd1 : big[30:23];
        es  = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
        d   = eg - es;
        mg  = {1'b0, (big[30:23] != '0), big[22:0], 25'd0};
        ms  = {1'b0, (sml[30:23] != '0), sml[22:0], 25'd0};
        // align the smaller operand, jam shifted-out bits into the lsb
        if (d > 8'd49) begin
            stk = |ms;
            ms  = '0;
        end else begin
            stk = |(ms & ((50'd1 << d) - 50'd1));
            ms  = ms >> d;
        end
        ms  = ms | {49'd0, stk};
        sum = (big[31] == sml[31]) ? (mg + ms) : (mg - ms);
        if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) return FVN_QNAN;
        if (a_inf) return a;
        if (b_inf) return b;
        if ((a[30:0] == '0) && (b[30:0] == '0)) return {a[31] & b[31], 31'd0};
        if (sum == '0) return 32'd0;
        return fp_round(big[31], sum, $signed({5'd0, eg}) - 13'sd175);
    endfunction

endpackage

/* rtl/core/fvn_vec_mul.sv */
// Three-lane binary32 multiplier with registered products.
// Depends on fvn_pkg.
module fvn_vec_mul
    import fvn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_en,
    input  t_vec_in i_a,
    input  t_vec_in i_b,
    output t_vec_in o_p
);
    t_vec_in r_p;
    t_vec_in n_p;

    // Multiply each lane
    always_comb begin
        n_p.x_bits = fp_mul(i_a.x_bits, i_b.x_bits);
        n_p.y_bits = fp_mul(i_a.y_bits, i_b.y_bits);
        n_p.z_bits = fp_mul(i_a.z_bits, i_b.z_bits);
    end

    // Hold products while stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;
endmodule

/* rtl/core/fast_rsqrt_vec3_normalize_unit.sv */
// Normalizes a binary32 3-vector by the fast inverse square root with one
// Newton step, every operation rounded to nearest even. The pipeline stages are
// square, two adds, halve and seed, three Newton multiplies and a subtract,
// final scale, one floating-point operation per stage. Vectors are taken
// every cycle unless the output stalls a full pipe; empty stages still fill.
// Depends on fvn_pkg and fvn_vec_mul.
module fast_rsqrt_vec3_normalize_unit
    import fvn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_vec_in  i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_vec_out o_data
);
    logic [FVN_STAGES:1]   r_vld;
    logic [FVN_STAGES+1:1] adv;
    t_vec_in               r_vec [1:FVN_STAGES-1];
    t_vec_in               sq;
    t_vec_in               prod;
    logic [31:0]           r2_a, r2_zz, r3_s, r4_half, r4_r, r5_hr, r5_r;
    logic [31:0]           r6_t, r6_r, r7_u, r7_r, r8_r;

    // Advance a stage when it is empty or its successor advances
    always_comb begin
        adv[FVN_STAGES+1] = i_ready;
        for (int k = FVN_STAGES; k >= 1; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end
    assign o_ready = adv[1];
    assign o_valid = r_vld[FVN_STAGES];

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[1]) r_vld[1] <= i_valid;
            for (int k = 2; k <= FVN_STAGES; k++) begin
                if (adv[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Carry the components to the final scale
    always_ff @(posedge i_clk) begin
        if (adv[1]) r_vec[1] <= i_data;
        for (int k = 2; k <= FVN_STAGES - 1; k++) begin
            if (adv[k]) r_vec[k] <= r_vec[k-1];
        end
    end

    // Square the components
    fvn_vec_mul u_square (
        .i_clk (i_clk),
        .i_en  (adv[1]),
        .i_a   (i_data),
        .i_b   (i_data),
        .o_p   (sq)
    );

    // Sum, seed and Newton step
    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r2_a  <= fp_add(sq.x_bits, sq.y_bits);
            r2_zz <= sq.z_bits;
        end
        if (adv[3]) r3_s <= fp_add(r2_a, r2_zz);
        if (adv[4]) begin
            r4_half <= fp_mul(r3_s, FVN_ONE_HALF);
            r4_r    <= FVN_SEED_MAGIC - {1'b0, r3_s[31:1]};
        end
        if (adv[5]) begin
            r5_hr <= fp_mul(r4_half, r4_r);
            r5_r  <= r4_r;
        end
        if (adv[6]) begin
            r6_t <= fp_mul(r5_hr, r5_r);
            r6_r <= r5_r;
        end
        if (adv[7]) begin
            r7_u <= fp_add(FVN_THREE_HALF, {~r6_t[31], r6_t[30:0]});
            r7_r <= r6_r;
        end
        if (adv[8]) r8_r <= fp_mul(r7_r, r7_u);
    end

    // Scale the components
    fvn_vec_mul u_scale (
        .i_clk (i_clk),
        .i_en  (adv[FVN_STAGES]),
        .i_a   (r_vec[FVN_STAGES-1]),
        .i_b   ({r8_r, r8_r, r8_r}),
        .o_p   (prod)
    );

    assign o_data.nx_bits = prod.x_bits;
    assign o_data.ny_bits = prod.y_bits;
    assign o_data.nz_bits = prod.z_bits;
endmodule

/* rtl/core/fvn_checker.sv */
// Port checker for the vector normalize unit, bound to the top level.
// Depends on fvn_pkg and fast_rsqrt_vec3_normalize_unit_assert.svh.
`include "fast_rsqrt_vec3_normalize_unit_assert.svh"
module fvn_checker
    import fvn_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_valid,
    input logic     o_ready,
    input t_vec_in  i_data,
    input logic     o_valid,
    input logic     i_ready,
    input t_vec_out o_data
);
    logic [4:0] r_cnt;
    logic       in_acc, out_acc;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    // Track transactions in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 5'(in_acc) - 5'(out_acc);
        end
    end

    `FVN_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_data))
    `FVN_ASSERT(a_cnt_cap, i_clk, i_rst_n, r_cnt <= 5'(FVN_STAGES))
    `FVN_ASSERT(a_out_has_src, i_clk, i_rst_n, o_valid |-> r_cnt != 5'd0)
    `FVN_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid)
endmodule

bind fast_rsqrt_vec3_normalize_unit fvn_checker u_fvn_checker (.*);
